// File: hw/rtl/cbez_pkg.sv
// Shared widths, types and register codes for the cubic Bezier point unit.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package cbez_pkg;

    localparam int COORD_W = 12;
    localparam int FRAC_W  = 16;
    localparam int T_W     = FRAC_W + 1;
    localparam int T_SW    = T_W + 1;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

    // level 1 (linear)
    localparam int D1_W = COORD_W + 1;
    localparam int M1_W = D1_W + T_SW;
    localparam int Q_W  = COORD_W + FRAC_W;
    // level 2 (quadratic)
    localparam int D2_W = Q_W + 1;
    localparam int M2_W = D2_W + T_SW;
    localparam int R_W  = COORD_W + 2 * FRAC_W;
    // level 3 (cubic), multiplied in two halves
    localparam int D3_W = R_W + 1;
    localparam int LO_W = (D3_W + 1) / 2;
    localparam int HI_W = D3_W - LO_W;
    localparam int PL_W = LO_W + T_W;
    localparam int PH_W = HI_W + T_SW;
    localparam int S_W  = COORD_W + 3 * FRAC_W;

    localparam int IDX_W = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [3:0] x;
        coord_t [3:0] y;
    } ctrl_pts_t;

    typedef enum logic [IDX_W-1:0] {
        REG_CTRL0_X = 4'd0,
        REG_CTRL0_Y = 4'd1,
        REG_CTRL1_X = 4'd2,
        REG_CTRL1_Y = 4'd3,
        REG_CTRL2_X = 4'd4,
        REG_CTRL2_Y = 4'd5,
        REG_CTRL3_X = 4'd6,
        REG_CTRL3_Y = 4'd7
    } reg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/cbez_cfg_regs.sv
// Control point register file, written through the configuration channel.
// Depends on cbez_pkg.
`default_nettype none

module cbez_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [cbez_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [cbez_pkg::COORD_W-1:0] cfg_data,
    output cbez_pkg::ctrl_pts_t              pts
);

    cbez_pkg::ctrl_pts_t pts_reg;
    cbez_pkg::ctrl_pts_t pts_next;

    always_comb
    begin
        pts_next = pts_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                cbez_pkg::REG_CTRL0_X: pts_next.x[0] = cfg_data;
                cbez_pkg::REG_CTRL0_Y: pts_next.y[0] = cfg_data;
                cbez_pkg::REG_CTRL1_X: pts_next.x[1] = cfg_data;
                cbez_pkg::REG_CTRL1_Y: pts_next.y[1] = cfg_data;
                cbez_pkg::REG_CTRL2_X: pts_next.x[2] = cfg_data;
                cbez_pkg::REG_CTRL2_Y: pts_next.y[2] = cfg_data;
                cbez_pkg::REG_CTRL3_X: pts_next.x[3] = cfg_data;
                cbez_pkg::REG_CTRL3_Y: pts_next.y[3] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= '0;
        end
        else
        begin
            pts_reg <= pts_next;
        end
    end

    assign pts = pts_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cbez_datapath.sv
// Five-stage de Casteljau pipeline: linear, quadratic, cubic difference,
// split cubic multiply, recombine. Exact sums with 3*FRAC_W fraction bits.
// Depends on cbez_pkg.
`default_nettype none

module cbez_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [cbez_pkg::T_W-1:0]      in_t,
    input  wire cbez_pkg::ctrl_pts_t           pts,
    output logic                               out_valid,
    output logic signed [cbez_pkg::S_W-1:0]    out_x,
    output logic signed [cbez_pkg::S_W-1:0]    out_y
);

    localparam int COORD_W = cbez_pkg::COORD_W;
    localparam int FRAC_W  = cbez_pkg::FRAC_W;
    localparam int T_W     = cbez_pkg::T_W;
    localparam int T_SW    = cbez_pkg::T_SW;
    localparam int D1_W    = cbez_pkg::D1_W;
    localparam int M1_W    = cbez_pkg::M1_W;
    localparam int Q_W     = cbez_pkg::Q_W;
    localparam int D2_W    = cbez_pkg::D2_W;
    localparam int M2_W    = cbez_pkg::M2_W;
    localparam int R_W     = cbez_pkg::R_W;
    localparam int D3_W    = cbez_pkg::D3_W;
    localparam int LO_W    = cbez_pkg::LO_W;
    localparam int HI_W    = cbez_pkg::HI_W;
    localparam int PL_W    = cbez_pkg::PL_W;
    localparam int PH_W    = cbez_pkg::PH_W;
    localparam int S_W     = cbez_pkg::S_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [T_W-1:0] t1_reg, t2_reg, t3_reg;

    logic signed [T_SW-1:0] ts0, ts1, ts3;
    assign ts0 = $signed({1'b0, in_t});
    assign ts1 = $signed({1'b0, t1_reg});
    assign ts3 = $signed({1'b0, t3_reg});

    logic signed [S_W-1:0] s_out [2];

    genvar ax, k;
    generate
        for (ax = 0; ax < 2; ax++)
        begin : g_axis
            logic signed [COORD_W-1:0] p [4];
            logic signed [Q_W-1:0]     q_reg [3];
            logic signed [R_W-1:0]     r_reg [2];
            logic signed [R_W-1:0]     r0_3_reg;
            logic signed [D3_W-1:0]    d3_reg;
            logic signed [R_W-1:0]     r0_4_reg;
            logic [PL_W-1:0]           pl_reg;
            logic signed [PH_W-1:0]    ph_reg;
            logic signed [S_W-1:0]     s_reg;
            logic [LO_W-1:0]           d3_lo;
            logic signed [HI_W-1:0]    d3_hi;
            logic [PL_W-1:0]           pl_next;
            logic signed [PH_W-1:0]    ph_next;
            logic signed [S_W-1:0]     s_next;

            for (k = 0; k < 4; k++)
            begin : g_pt
                if (ax == 0)
                begin : g_x
                    assign p[k] = $signed(pts.x[k]);
                end
                else
                begin : g_y
                    assign p[k] = $signed(pts.y[k]);
                end
            end

            for (k = 0; k < 3; k++)
            begin : g_lin
                logic signed [D1_W-1:0] d1;
                logic signed [M1_W-1:0] m1;
                logic signed [M1_W-1:0] sum1;
                assign d1   = D1_W'(p[k+1]) - D1_W'(p[k]);
                assign m1   = M1_W'(d1) * M1_W'(ts0);
                assign sum1 = (M1_W'(p[k]) <<< FRAC_W) + m1;
                always_ff @(posedge clk)
                begin
                    q_reg[k] <= sum1[Q_W-1:0];
                end
            end

            for (k = 0; k < 2; k++)
            begin : g_quad
                logic signed [D2_W-1:0] d2;
                logic signed [M2_W-1:0] m2;
                logic signed [M2_W-1:0] sum2;
                assign d2   = D2_W'(q_reg[k+1]) - D2_W'(q_reg[k]);
                assign m2   = M2_W'(d2) * M2_W'(ts1);
                assign sum2 = (M2_W'(q_reg[k]) <<< FRAC_W) + m2;
                always_ff @(posedge clk)
                begin
                    r_reg[k] <= sum2[R_W-1:0];
                end
            end

            assign d3_lo   = d3_reg[LO_W-1:0];
            assign d3_hi   = $signed(d3_reg[D3_W-1:LO_W]);
            assign pl_next = PL_W'(d3_lo) * PL_W'(t3_reg);
            assign ph_next = PH_W'(d3_hi) * PH_W'(ts3);
            assign s_next  = (S_W'(r0_4_reg) <<< FRAC_W)
                           + (S_W'(ph_reg) <<< LO_W)
                           + $signed(S_W'(pl_reg));

            always_ff @(posedge clk)
            begin
                d3_reg   <= D3_W'(r_reg[1]) - D3_W'(r_reg[0]);
                r0_3_reg <= r_reg[0];
                pl_reg   <= pl_next;
                ph_reg   <= ph_next;
                r0_4_reg <= r0_3_reg;
                s_reg    <= s_next;
            end

            assign s_out[ax] = s_reg;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        t1_reg <= in_t;
        t2_reg <= t1_reg;
        t3_reg <= t2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_x     = s_out[0];
    assign out_y     = s_out[1];

    a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg == $past(v1_reg))
        else $error("valid bit lost between linear and quadratic stages");

    a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> $past(in_valid, 5))
        else $error("result valid without matching request");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (t1_reg <= cbez_pkg::T_ONE))
        else $error("parameter above one entered the pipeline");

endmodule

`default_nettype wire

// File: hw/rtl/cbez_round.sv
// Truncate the exact curve sum toward zero and register the result.
// Depends on cbez_pkg.
`default_nettype none

module cbez_round (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic signed [cbez_pkg::S_W-1:0] sum_x,
    input  wire logic signed [cbez_pkg::S_W-1:0] sum_y,
    output logic                                result_valid,
    output logic signed [cbez_pkg::COORD_W-1:0] curve_x,
    output logic signed [cbez_pkg::COORD_W-1:0] curve_y
);

    localparam int S_W    = cbez_pkg::S_W;
    localparam int SH     = 3 * cbez_pkg::FRAC_W;
    localparam int COORD_W = cbez_pkg::COORD_W;

    logic                      valid_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic signed [COORD_W-1:0] x_next, y_next;
    logic                      x_up, y_up;

    // floor plus one where negative with a nonzero fraction
    assign x_up   = sum_x[S_W-1] && (|sum_x[SH-1:0]);
    assign y_up   = sum_y[S_W-1] && (|sum_y[SH-1:0]);
    assign x_next = $signed(sum_x[S_W-1:SH]) + $signed({{(COORD_W-1){1'b0}}, x_up});
    assign y_next = $signed(sum_y[S_W-1:SH]) + $signed({{(COORD_W-1){1'b0}}, y_up});

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    assign result_valid = valid_reg;
    assign curve_x      = x_reg;
    assign curve_y      = y_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cubic_bezier_point_unit.sv
// Top level of the cubic Bezier point unit: input stage, control registers,
// de Casteljau pipeline and truncation stage.
// Depends on cbez_pkg, cbez_cfg_regs, cbez_datapath, cbez_round.
//
//   channel   handshake               payload
//   request   start / busy            param_t
//   result    result_valid (strobe)   curve_x, curve_y
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle; busy and cfg_ready are constant, nothing stalls.
// A result strobes once its request has passed the input register, the five
// pipeline stages and the output register.
// Reset clears valid bits and the control points; no clearing pass.
`default_nettype none

module cubic_bezier_point_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [cbez_pkg::T_W-1:0]        param_t,
    output logic                                 result_valid,
    output logic signed [cbez_pkg::COORD_W-1:0]  curve_x,
    output logic signed [cbez_pkg::COORD_W-1:0]  curve_y,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cbez_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [cbez_pkg::COORD_W-1:0]    cfg_data
);

    localparam int T_W = cbez_pkg::T_W;

    logic                  v0_reg;
    logic [T_W-1:0]        t0_reg;
    logic [T_W-1:0]        t_sat;
    cbez_pkg::ctrl_pts_t   pts;
    logic                  dp_valid;
    logic signed [cbez_pkg::S_W-1:0] sum_x, sum_y;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // saturate t above one
    assign t_sat = param_t[cbez_pkg::FRAC_W] ? cbez_pkg::T_ONE : param_t;

    always_ff @(posedge clk)
    begin
        t0_reg <= t_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    cbez_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pts       (pts)
    );

    cbez_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_t      (t0_reg),
        .pts       (pts),
        .out_valid (dp_valid),
        .out_x     (sum_x),
        .out_y     (sum_y)
    );

    cbez_round u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dp_valid),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .result_valid (result_valid),
        .curve_x      (curve_x),
        .curve_y      (curve_y)
    );

endmodule

`default_nettype wire

// File: sim/tb_cubic_bezier_point_unit.sv
// Testbench for cubic_bezier_point_unit: sets the control points, sends curve parameters and
// checks each strobed curve point against an exact fixed-point evaluation kept here.
// Depends on cbez_pkg and the cubic_bezier_point_unit RTL.
`timescale 1ns / 1ps

module tb_cubic_bezier_point_unit;

    localparam int T_W     = cbez_pkg::T_W;
    localparam int IDX_W   = cbez_pkg::IDX_W;
    localparam int COORD_W = cbez_pkg::COORD_W;
    localparam int FRAC_W  = cbez_pkg::FRAC_W;
    localparam logic [T_W-1:0] T_ONE = cbez_pkg::T_ONE;

    localparam int RESULT_LATENCY = 7;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 116;
    localparam int PHASE_COUNT    = 8;

    typedef cbez_pkg::coord_t    coord_t;
    typedef cbez_pkg::ctrl_pts_t ctrl_pts_t;

    typedef struct {
        coord_t x;
        coord_t y;
    } curve_point_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [T_W-1:0]       param_t = '0;
    logic                 result_valid;
    coord_t               curve_x;
    coord_t               curve_y;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;

    coord_t               ctrl_x [4];
    coord_t               ctrl_y [4];
    curve_point_t         pending_points [$];
    int                   error_count = 0;
    bit                   steady_stream = 1'b0;

    cubic_bezier_point_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .param_t      (param_t),
        .result_valid (result_valid),
        .curve_x      (curve_x),
        .curve_y      (curve_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic coord_t truncate_coord(longint acc);
        longint mag;
        if (acc < 0)
        begin
            mag = -acc;
            return coord_t'(-(mag >>> (3 * FRAC_W)));
        end
        return coord_t'(acc >>> (3 * FRAC_W));
    endfunction

    function automatic curve_point_t bezier_point(logic [T_W-1:0] t_raw);
        longint       t;
        longint       u;
        longint       w [4];
        longint       acc_x;
        longint       acc_y;
        curve_point_t pt;
        t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
        u = longint'(T_ONE) - t;
        w[0] = u * u * u;
        w[1] = 3 * u * u * t;
        w[2] = 3 * u * t * t;
        w[3] = t * t * t;
        acc_x = 0;
        acc_y = 0;
        for (int k = 0; k < 4; k++)
        begin
            acc_x += w[k] * longint'(ctrl_x[k]);
            acc_y += w[k] * longint'(ctrl_y[k]);
        end
        pt.x = truncate_coord(acc_x);
        pt.y = truncate_coord(acc_y);
        return pt;
    endfunction

    // Track control points as the block takes them; out-of-range indexes are dropped.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ctrl_x[k] <= '0;
                ctrl_y[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && cfg_index <= cbez_pkg::REG_CTRL3_Y)
        begin
            if (cfg_index[0])
                ctrl_y[cfg_index[2:1]] <= coord_t'(cfg_data);
            else
                ctrl_x[cfg_index[2:1]] <= coord_t'(cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_points.push_back(bezier_point(param_t));
    end

    always @(posedge clk)
    begin
        curve_point_t exp_pt;
        if (rst_n && result_valid)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result with no pending request: curve_x %0d curve_y %0d",
                       curve_x, curve_y);
                error_count++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (curve_x !== exp_pt.x)
                begin
                    $error("curve_x expected %0d actual %0d", exp_pt.x, curve_x);
                    error_count++;
                end
                if (curve_y !== exp_pt.y)
                begin
                    $error("curve_y expected %0d actual %0d", exp_pt.y, curve_y);
                    error_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_stream)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_request(input logic [T_W-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        param_t <= t;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Leave cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold off until every pending point is out, then let the pipeline settle.
    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_points.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_points(input ctrl_pts_t p);
        write_reg(cbez_pkg::REG_CTRL0_X, p.x[0]);
        write_reg(cbez_pkg::REG_CTRL0_Y, p.y[0]);
        write_reg(cbez_pkg::REG_CTRL1_X, p.x[1]);
        write_reg(cbez_pkg::REG_CTRL1_Y, p.y[1]);
        write_reg(cbez_pkg::REG_CTRL2_X, p.x[2]);
        write_reg(cbez_pkg::REG_CTRL2_Y, p.y[2]);
        write_reg(cbez_pkg::REG_CTRL3_X, p.x[3]);
        write_reg(cbez_pkg::REG_CTRL3_Y, p.y[3]);
        cfg_valid <= 1'b0;
    endtask

    function automatic coord_t pick_coord(int mode);
        case (mode)
            0:       return coord_t'($urandom);
            1:       return $urandom_range(0, 1) ? coord_t'(2047) : coord_t'(-2048);
            default: return coord_t'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    function automatic logic [T_W-1:0] pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return T_W'($urandom_range(0, T_ONE));
        if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return T_W'(1);
                2:       return T_ONE - 1'b1;
                default: return T_ONE;
            endcase
        end
        return T_W'($urandom);
    endfunction

    task automatic test_reset_state();
        send_request(T_W'(0));
        send_request(T_ONE);
        send_request(T_W'($urandom_range(1, T_ONE - 1)));
        drain();
    endtask

    task automatic test_directed_extremes();
        ctrl_pts_t p;
        p.x = '{coord_t'(2047), coord_t'(-2048), coord_t'(2047), coord_t'(-2048)};
        p.y = '{coord_t'(2047), coord_t'(-2048), coord_t'(-2048), coord_t'(2047)};
        set_points(p);
        send_request(T_W'(0));
        send_request(T_W'(1));
        send_request(T_W'(T_ONE >> 1));
        send_request(T_W'(T_ONE >> 2));
        send_request(T_ONE - 1'b1);
        send_request(T_ONE);
        send_request(T_ONE + 1'b1);
        send_request({T_W{1'b1}});
        send_request(T_ONE | T_W'(16'h5a5a));
        drain();
        // Tiny, mostly negative x hull, full-range y: exercise truncation toward zero.
        p.x = '{coord_t'(1), coord_t'(-1), coord_t'(-3), coord_t'(-1)};
        p.y = '{coord_t'(-2048), coord_t'(2047), coord_t'(0), coord_t'(-1)};
        set_points(p);
        send_request(T_W'(1));
        send_request(T_W'(12345));
        send_request(T_W'(T_ONE >> 1));
        send_request(T_ONE - 1'b1);
        drain();
    endtask

    task automatic test_ignored_index();
        for (int k = 0; k < 4; k++)
            write_reg(IDX_W'($urandom_range(cbez_pkg::REG_CTRL3_Y + 1, 2 ** IDX_W - 1)),
                      COORD_W'($urandom));
        cfg_valid <= 1'b0;
        send_request(T_W'(0));
        send_request(T_W'(T_ONE >> 1));
        send_request(T_ONE);
        drain();
    endtask

    task automatic test_random_curves();
        ctrl_pts_t p;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p.x[k] = pick_coord(phase % 3);
                p.y[k] = pick_coord(phase % 3);
            end
            set_points(p);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 30 == 0)
                    steady_stream = ($urandom_range(0, 2) == 0);
                send_request(pick_param());
            end
            steady_stream = 1'b0;
            drain();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_extremes();
        test_ignored_index();
        test_random_curves();
        drain();
        if (pending_points.size() != 0)
        begin
            $error("%0d curve points never arrived", pending_points.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cbez_pkg.sv
hw/rtl/cbez_cfg_regs.sv
hw/rtl/cbez_datapath.sv
hw/rtl/cbez_round.sv
hw/rtl/cubic_bezier_point_unit.sv
sim/tb_cubic_bezier_point_unit.sv
